FILE: hw/rtl/crfp_pkg.sv
// Shared types and constants of the settings frame parser.
package crfp_pkg;

    localparam int POS_W = 9;
    localparam int HEADER_SKIP_DEF = 12;
    localparam int MID_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 2;

    localparam logic [7:0] TYPE_SHORT_MAX = 8'h02;
    localparam logic [7:0] TYPE_LAST_KNOWN = 8'h08;
    localparam logic [3:0] TYPE_SINGLE_BYTE = 4'h7;

    localparam logic [2:0] REC_LEFT_SHORT = 3'd2;
    localparam logic [2:0] REC_LEFT_LONG = 3'd4;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_REJECTED  = 2'd1,
        STATUS_STOPPED   = 2'd2,
        STATUS_TRUNCATED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_SKIP = 3'd0,
        OP_ACK  = 3'd1,
        OP_LEN  = 3'd2,
        OP_BODY = 3'd3,
        OP_TAIL = 3'd4
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] data;
        logic       last;
        logic       hdr_short;
        logic       body_short;
    } op_t;

    typedef struct packed {
        logic        record_valid;
        logic [3:0]  record_type;
        logic [31:0] record_value;
        logic        frame_done;
        status_t     frame_status;
    } res_t;

endpackage

FILE: hw/rtl/crfp_fifo.sv
// Small register queue with push/full and pop/empty sides.
module crfp_fifo #(
    parameter type T = logic,
    parameter int DEPTH = 4
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  T     wdata,
    input  logic pop,
    output logic empty,
    output T     rdata
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    T mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic do_push;
    logic do_pop;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

FILE: hw/rtl/crfp_front.sv
// Front end: tracks the byte position and payload length and tags each byte.
module crfp_front #(
    parameter int HEADER_SKIP = crfp_pkg::HEADER_SKIP_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [7:0]     in_byte,
    input  logic           in_last,
    input  logic           op_full,
    output logic           op_push,
    output crfp_pkg::op_t  op
);

    localparam int POS_W = crfp_pkg::POS_W;
    localparam logic [POS_W-1:0] ACK_POS = POS_W'(HEADER_SKIP);
    localparam logic [POS_W-1:0] LEN_POS = POS_W'(HEADER_SKIP + 1);
    localparam logic [POS_W-1:0] REC_POS = POS_W'(HEADER_SKIP + 2);
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] len_eff;
    logic [POS_W-1:0] body_off;
    logic [POS_W:0] done_cnt;
    logic accept;

    assign accept = in_valid && !op_full;
    assign op_push = accept;
    assign body_off = pos_reg - REC_POS;
    assign done_cnt = {1'b0, pos_reg} + (POS_W + 1)'(1) - {1'b0, REC_POS};

    always_comb
    begin
        op.data = in_byte;
        op.last = in_last;
        op.hdr_short = (pos_reg < LEN_POS);
        if (pos_reg == ACK_POS)
        begin
            op.kind = crfp_pkg::OP_ACK;
        end
        else if (pos_reg == LEN_POS)
        begin
            op.kind = crfp_pkg::OP_LEN;
        end
        else if (pos_reg >= REC_POS && body_off < {1'b0, len_reg})
        begin
            op.kind = crfp_pkg::OP_BODY;
        end
        else if (pos_reg >= REC_POS)
        begin
            op.kind = crfp_pkg::OP_TAIL;
        end
        else
        begin
            op.kind = crfp_pkg::OP_SKIP;
        end
        len_eff = (op.kind == crfp_pkg::OP_LEN) ? in_byte : len_reg;
        op.body_short = (done_cnt < {2'b00, len_eff});
    end

    always_comb
    begin
        pos_next = pos_reg;
        len_next = len_reg;
        if (accept)
        begin
            if (op.kind == crfp_pkg::OP_LEN)
            begin
                len_next = in_byte;
            end
            if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + POS_W'(1);
            end
            if (in_last)
            begin
                pos_next = '0;
                len_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            len_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            len_reg <= len_next;
        end
    end

endmodule

FILE: hw/rtl/crfp_back.sv
// Back end: assembles records, keeps the frame flags and builds the results.
module crfp_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           op_valid,
    input  crfp_pkg::op_t  op,
    output logic           op_pop,
    input  logic           res_full,
    output logic           res_push,
    output crfp_pkg::res_t res
);

    logic rej_reg, rej_next;
    logic stop_reg, stop_next;
    logic [3:0] type_reg, type_next;
    logic [2:0] left_reg, left_next;
    logic [31:0] acc_reg, acc_next;
    logic fire;
    logic done;

    assign fire = op_valid && !res_full;
    assign op_pop = fire;

    always_comb
    begin
        rej_next = rej_reg;
        stop_next = stop_reg;
        type_next = type_reg;
        left_next = left_reg;
        acc_next = acc_reg;
        done = 1'b0;
        if (fire)
        begin
            if (left_reg != '0)
            begin
                if (type_reg == crfp_pkg::TYPE_SINGLE_BYTE)
                begin
                    if (left_reg == crfp_pkg::REC_LEFT_LONG)
                    begin
                        acc_next = {24'd0, op.data};
                    end
                end
                else
                begin
                    acc_next = {acc_reg[23:0], op.data};
                end
                left_next = left_reg - 3'd1;
                done = (left_reg == 3'd1);
            end
            else if (!rej_reg && !stop_reg)
            begin
                case (op.kind)
                    crfp_pkg::OP_ACK:
                    begin
                        if (op.data != 8'd0)
                        begin
                            rej_next = 1'b1;
                        end
                    end
                    crfp_pkg::OP_BODY:
                    begin
                        if (op.data <= crfp_pkg::TYPE_LAST_KNOWN)
                        begin
                            type_next = op.data[3:0];
                            acc_next = '0;
                            left_next = (op.data <= crfp_pkg::TYPE_SHORT_MAX) ?
                                crfp_pkg::REC_LEFT_SHORT : crfp_pkg::REC_LEFT_LONG;
                        end
                        else
                        begin
                            stop_next = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        res.record_valid = done;
        res.record_type = done ? type_reg : 4'd0;
        res.record_value = done ? acc_next : 32'd0;
        res.frame_done = op.last;
        if (!op.last)
        begin
            res.frame_status = crfp_pkg::STATUS_OK;
        end
        else if (rej_next)
        begin
            res.frame_status = crfp_pkg::STATUS_REJECTED;
        end
        else if (op.hdr_short || left_next != '0)
        begin
            res.frame_status = crfp_pkg::STATUS_TRUNCATED;
        end
        else if (stop_next)
        begin
            res.frame_status = crfp_pkg::STATUS_STOPPED;
        end
        else if (op.body_short)
        begin
            res.frame_status = crfp_pkg::STATUS_TRUNCATED;
        end
        else
        begin
            res.frame_status = crfp_pkg::STATUS_OK;
        end
        res_push = fire && (done || op.last);

        if (fire && op.last)
        begin
            rej_next = 1'b0;
            stop_next = 1'b0;
            type_next = '0;
            left_next = '0;
            acc_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rej_reg <= 1'b0;
            stop_reg <= 1'b0;
            type_reg <= '0;
            left_reg <= '0;
            acc_reg <= '0;
        end
        else
        begin
            rej_reg <= rej_next;
            stop_reg <= stop_next;
            type_reg <= type_next;
            left_reg <= left_next;
            acc_reg <= acc_next;
        end
    end

endmodule

FILE: hw/rtl/config_record_frame_parser.sv
// Top level of the settings frame parser: front end, op queue, back end, result queue.
//
//  Channel   Direction  Handshake            Payload
//  frame     in         push / full          frame_byte, frame_last
//  record    out        empty / pop          record_valid, record_type, record_value,
//                                            frame_done, frame_status
//
// The front end tags each byte as it is taken and the back end handles it from the op queue, so one
// request is taken every cycle while the op queue is not full.
// A result is built by the back end once its byte leaves the op queue, and is then registered in the result queue.
// Reset clears both queues and all frame state; no clearing pass is needed.
// A stalled output fills the result queue, then the op queue, then raises full.
module config_record_frame_parser #(
    parameter int HEADER_SKIP = crfp_pkg::HEADER_SKIP_DEF,
    parameter int MID_DEPTH = crfp_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = crfp_pkg::OUT_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  frame_byte,
    input  logic        frame_last,
    output logic        empty,
    input  logic        pop,
    output logic        record_valid,
    output logic [3:0]  record_type,
    output logic [31:0] record_value,
    output logic        frame_done,
    output logic [1:0]  frame_status
);

    crfp_pkg::op_t op_in;
    crfp_pkg::op_t op_out;
    crfp_pkg::res_t res_in;
    crfp_pkg::res_t res_out;
    logic op_push;
    logic op_full;
    logic op_empty;
    logic op_pop;
    logic res_push;
    logic res_full;

    crfp_front #(
        .HEADER_SKIP(HEADER_SKIP)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(push),
        .in_byte(frame_byte),
        .in_last(frame_last),
        .op_full(op_full),
        .op_push(op_push),
        .op(op_in)
    );

    assign full = op_full;

    crfp_fifo #(
        .T(crfp_pkg::op_t),
        .DEPTH(MID_DEPTH)
    ) u_op_fifo (
        .clk(clk),
        .rst_n(rst_n),
        .push(op_push),
        .full(op_full),
        .wdata(op_in),
        .pop(op_pop),
        .empty(op_empty),
        .rdata(op_out)
    );

    crfp_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .op_valid(!op_empty),
        .op(op_out),
        .op_pop(op_pop),
        .res_full(res_full),
        .res_push(res_push),
        .res(res_in)
    );

    crfp_fifo #(
        .T(crfp_pkg::res_t),
        .DEPTH(OUT_DEPTH)
    ) u_res_fifo (
        .clk(clk),
        .rst_n(rst_n),
        .push(res_push),
        .full(res_full),
        .wdata(res_in),
        .pop(pop),
        .empty(empty),
        .rdata(res_out)
    );

    assign record_valid = res_out.record_valid;
    assign record_type = res_out.record_type;
    assign record_value = res_out.record_value;
    assign frame_done = res_out.frame_done;
    assign frame_status = res_out.frame_status;

    a_result_has_content: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (record_valid || frame_done))
        else $error("Result carries neither a record nor a frame end.");

    a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !frame_done) |-> (frame_status == crfp_pkg::STATUS_OK))
        else $error("Frame status given on a result that does not end a frame.");

    a_no_record_fields_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !record_valid) |-> (record_type == 4'd0 && record_value == 32'd0))
        else $error("Record fields set without a record.");

    a_back_respects_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("Back end pushed into a full result queue.");

endmodule
